// File: rtl/ffpa_pkg.sv
// Shared constants, codes and types of the first-fit page run allocator.
package ffpa_pkg;

    localparam int NUM_PAGES = 1024;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int PTR_W     = $clog2(NUM_PAGES + 1);
    localparam int FRAME_W   = 20;
    localparam int CNT_W     = 11;
    localparam int CFG_W     = FRAME_W;
    localparam int SUM_W     = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;

    localparam logic [CNT_W-1:0] PAGES_MANAGED_RST = CNT_W'(1024);

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_ZERO_COUNT = 2'd2,
        ST_NOT_RUN    = 2'd3
    } status_t;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } kind_t;

    typedef enum logic {
        CFG_BASE_FRAME    = 1'b0,
        CFG_PAGES_MANAGED = 1'b1
    } cfg_idx_t;

    // One core map entry: used flag and run length at a run's first page.
    typedef struct packed {
        logic             used;
        logic [CNT_W-1:0] len;
    } map_entry_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    scan;
        logic    free_rd;
        logic    free_lim;
        logic    mark;
        logic    walk;
        logic    finish;
        status_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic count_zero;
        logic kind_free;
        logic idx_bad;
        logic scan_found;
        logic scan_none;
        logic len_zero;
        logic run_last;
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/ffpa_ifs.sv
// Request, response and configuration channel interfaces.
interface ffpa_req_if;
    import ffpa_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [CNT_W-1:0]   page_count;
    logic [FRAME_W-1:0] frame;

    modport source (output valid, output kind, output page_count, output frame, input ready);
    modport sink   (input valid, input kind, input page_count, input frame, output ready);
    modport mon    (input valid, input kind, input page_count, input frame, input ready);
endinterface

interface ffpa_rsp_if;
    import ffpa_pkg::*;
    logic               valid;
    logic               ready;
    status_t            status;
    logic [FRAME_W-1:0] frame_out;

    modport source (output valid, output status, output frame_out, input ready);
    modport sink   (input valid, input status, input frame_out, output ready);
    modport mon    (input valid, input status, input frame_out, input ready);
endinterface

interface ffpa_cfg_if;
    import ffpa_pkg::*;
    logic             valid;
    logic             ready;
    logic             index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
    modport mon    (input valid, input index, input data, input ready);
endinterface

// File: rtl/ffpa_dp.sv
// Datapath: core map memory, scan and walk counters, config and result registers.
module ffpa_dp
    import ffpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic               req_kind,
    input  logic [CNT_W-1:0]   req_page_count,
    input  logic [FRAME_W-1:0] req_frame,
    input  logic               cfg_valid,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output status_t            rsp_status,
    output logic [FRAME_W-1:0] rsp_frame_out
);

    map_entry_t         map_mem [NUM_PAGES];
    map_entry_t         rd_data_reg;
    logic [PAGE_W-1:0]  rd_addr;
    logic               map_we;
    map_entry_t         map_wdata;

    logic [FRAME_W-1:0] base_reg;
    logic [CNT_W-1:0]   pm_reg;

    logic               kind_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [FRAME_W-1:0] idx_reg;

    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   have_reg, have_next;
    logic [PTR_W-1:0]   start_reg, start_next;
    logic [PTR_W-1:0]   lim_reg, lim_next;
    logic               dv_reg, dv_next;
    logic [PTR_W-1:0]   didx_reg, didx_next;

    logic               out_valid_reg;
    status_t            out_status_reg;
    logic [FRAME_W-1:0] out_frame_reg;

    logic [SUM_W-1:0]   pm_wide;
    logic [PTR_W-1:0]   n_pages;
    logic               issue;
    logic               hit;
    logic [SUM_W-1:0]   free_sum;
    logic [PTR_W-1:0]   free_end;
    logic               out_free;

    // Usable pages: pages_managed clipped to the map depth.
    assign pm_wide  = SUM_W'(pm_reg);
    assign n_pages  = (pm_wide > SUM_W'(NUM_PAGES)) ? PTR_W'(NUM_PAGES) : PTR_W'(pm_reg);
    assign issue    = (ptr_reg < n_pages);
    assign hit      = dv_reg && !rd_data_reg.used
                      && (CNT_W'(have_reg + 1'b1) == count_reg);
    assign free_sum = SUM_W'(idx_reg[PAGE_W-1:0]) + SUM_W'(rd_data_reg.len);
    assign free_end = (free_sum > SUM_W'(NUM_PAGES)) ? PTR_W'(NUM_PAGES) : PTR_W'(free_sum);
    assign out_free = !out_valid_reg || rsp_ready;

    assign sts.clear_last = (ptr_reg[PAGE_W-1:0] == PAGE_W'(NUM_PAGES - 1));
    assign sts.count_zero = (count_reg == '0);
    assign sts.kind_free  = (kind_reg == KIND_FREE);
    assign sts.idx_bad    = (idx_reg >= FRAME_W'(NUM_PAGES));
    assign sts.scan_found = hit;
    assign sts.scan_none  = !dv_reg && !issue;
    assign sts.len_zero   = (rd_data_reg.len == '0);
    assign sts.run_last   = (PTR_W'(ptr_reg + 1'b1) == lim_reg);
    assign sts.out_free   = out_free;

    // Map port control
    always_comb
    begin
        rd_addr   = cmd.free_rd ? idx_reg[PAGE_W-1:0] : ptr_reg[PAGE_W-1:0];
        map_we    = cmd.clear || cmd.mark || cmd.walk;
        map_wdata = '{used: 1'b0, len: '0};
        if (cmd.mark)
        begin
            map_wdata.used = 1'b1;
            map_wdata.len  = (ptr_reg == start_reg) ? count_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[ptr_reg[PAGE_W-1:0]] <= map_wdata;
        end
        rd_data_reg <= map_mem[rd_addr];
    end

    // Scan and walk counters
    always_comb
    begin
        ptr_next   = ptr_reg;
        have_next  = have_reg;
        start_next = start_reg;
        lim_next   = lim_reg;
        dv_next    = dv_reg;
        didx_next  = didx_reg;
        if (cmd.load)
        begin
            ptr_next   = '0;
            have_next  = '0;
            start_next = '0;
            dv_next    = 1'b0;
        end
        else if (cmd.scan)
        begin
            if (hit)
            begin
                // rewind to the run start for the marking pass
                ptr_next = start_reg;
                lim_next = PTR_W'(SUM_W'(start_reg) + SUM_W'(count_reg));
                dv_next  = 1'b0;
            end
            else
            begin
                if (dv_reg)
                begin
                    if (!rd_data_reg.used)
                    begin
                        have_next = CNT_W'(have_reg + 1'b1);
                    end
                    else
                    begin
                        have_next  = '0;
                        start_next = PTR_W'(didx_reg + 1'b1);
                    end
                end
                dv_next   = issue;
                didx_next = ptr_reg;
                if (issue)
                begin
                    ptr_next = PTR_W'(ptr_reg + 1'b1);
                end
            end
        end
        else if (cmd.free_rd)
        begin
            ptr_next = PTR_W'(idx_reg[PAGE_W-1:0]);
        end
        else if (cmd.free_lim)
        begin
            lim_next = free_end;
        end
        else if (cmd.clear || cmd.mark || cmd.walk)
        begin
            ptr_next = PTR_W'(ptr_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            dv_reg  <= 1'b0;
        end
        else
        begin
            ptr_reg <= ptr_next;
            dv_reg  <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        have_reg  <= have_next;
        start_reg <= start_next;
        lim_reg   <= lim_next;
        didx_reg  <= didx_next;
        if (cmd.load)
        begin
            kind_reg  <= req_kind;
            count_reg <= req_page_count;
            idx_reg   <= FRAME_W'(req_frame - base_reg);
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            pm_reg   <= PAGES_MANAGED_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE_FRAME:    base_reg <= cfg_data[FRAME_W-1:0];
                CFG_PAGES_MANAGED: pm_reg   <= cfg_data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && out_free)
        begin
            out_status_reg <= cmd.code;
            if ((cmd.code == ST_OK) && (kind_reg == KIND_ALLOC))
            begin
                out_frame_reg <= FRAME_W'(base_reg + FRAME_W'(start_reg));
            end
            else
            begin
                out_frame_reg <= '0;
            end
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp_status    = out_status_reg;
    assign rsp_frame_out = out_frame_reg;

endmodule

// File: rtl/ffpa_ctrl.sv
// Controller: sequences map clear, request decode, scan, mark, free check, walk and result.
module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_valid,
    output logic    req_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DECODE   = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_MARK     = 8'b0001_0000,
        S_FREE_CHK = 8'b0010_0000,
        S_WALK     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.kind_free)
                begin
                    if (sts.idx_bad)
                    begin
                        code_next  = ST_NOT_RUN;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.free_rd = 1'b1;
                        state_next  = S_FREE_CHK;
                    end
                end
                else if (sts.count_zero)
                begin
                    code_next  = ST_ZERO_COUNT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_found)
                begin
                    state_next = S_MARK;
                end
                else if (sts.scan_none)
                begin
                    code_next  = ST_NO_ROOM;
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (sts.run_last)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_FREE_CHK:
            begin
                if (sts.len_zero)
                begin
                    code_next  = ST_NOT_RUN;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.free_lim = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (sts.run_last)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the result register can take the beat
                cmd.finish = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

endmodule

// File: rtl/first_fit_page_run_allocator.sv
// First-fit page run allocator over a 1024-entry core map, one request at a time.
// Allocate: accept, decode, a scan from page 0 until the run is found (the map read is
// registered), a pass that marks the run's pages, then the result. Free: accept, decode,
// a run length check, a walk that frees the run, then the result; bad requests end early.
// The single-ported core map memory sets the pace: one map read or write per cycle.
// After reset the map is swept to all free, page by page, with req.ready low.
module first_fit_page_run_allocator
    import ffpa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ffpa_req_if.sink   req,
    ffpa_rsp_if.source rsp,
    ffpa_cfg_if.sink   cfg
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg.ready = 1'b1;

    ffpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffpa_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_kind       (req.kind),
        .req_page_count (req.page_count),
        .req_frame      (req.frame),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_status     (rsp.status),
        .rsp_frame_out  (rsp.frame_out)
    );

endmodule

// File: rtl/ffpa_chk.sv
// Port-level checker for the allocator, bound to the top level.
module ffpa_chk
    import ffpa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    ffpa_req_if.sink   req,
    ffpa_rsp_if.source rsp
);

    // A stalled response beat holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status) && $stable(rsp.frame_out))
        else $error("response beat changed while stalled");

    // Only a successful allocate reports a frame.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> rsp.frame_out == '0)
        else $error("failed request returned a nonzero frame");

    // One request in flight: no new request right after an accepted one.
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while another is in work");

    // A new response appears only at the end of a request's work.
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> !$past(req.ready))
        else $error("response appeared while the block was idle");

endmodule

bind first_fit_page_run_allocator ffpa_chk u_ffpa_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);
